// ----- rtl/nfdc_pkg.sv -----
// Package for the NTP fixed-point / binary64 converter.
// Holds operation codes and the result payload type; no dependencies.
`timescale 1ns / 1ps
package nfdc_pkg;
    typedef enum logic [1:0] {
        OP_LONG_TO_DBL  = 2'd0,
        OP_SHORT_TO_DBL = 2'd1,
        OP_DBL_TO_LONG  = 2'd2,
        OP_DBL_TO_SHORT = 2'd3
    } t_op;

    localparam int unsigned EXP_BIAS = 1023;

    typedef struct packed {
        logic [63:0] double_result;
        logic [63:0] fixed_result;
        logic        out_of_range;
    } t_result;
endpackage

// ----- rtl/nfdc_if.sv -----
// Valid/ready channel interfaces for the converter.
// Depends on nothing; payloads are flat fields.
`timescale 1ns / 1ps
interface nfdc_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [63:0] fixed_word;
    logic [63:0] double_bits;
    modport source (output valid, operation, fixed_word, double_bits, input ready);
    modport sink (input valid, operation, fixed_word, double_bits, output ready);
endinterface

interface nfdc_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] double_result;
    logic [63:0] fixed_result;
    logic        out_of_range;
    modport source (output valid, double_result, fixed_result, out_of_range, input ready);
    modport sink (input valid, double_result, fixed_result, out_of_range, output ready);
endinterface

// ----- rtl/nfdc_to_dbl.sv -----
// Fixed-point (long or short) to binary64 conversion, combinational.
// Depends on nfdc_pkg.
`timescale 1ns / 1ps
module nfdc_to_dbl
    import nfdc_pkg::*;
(
    input  logic        i_short,
    input  logic [63:0] i_word,
    output logic [63:0] o_double
);
    logic [63:0] mag;
    logic        sgn;
    logic [6:0]  lz;
    logic        found;
    logic [63:0] norm;
    logic [52:0] mant;
    logic        rnd;
    logic [53:0] mant_r;
    logic [10:0] expo;
    logic [10:0] e_base;

    always_comb begin
        sgn = 1'b0;
        if (i_short) begin
            sgn = i_word[31];
            mag = {16'd0, (sgn ? ~i_word[31:0] : i_word[31:0]), 16'd0};
        end else begin
            mag = i_word;
        end
        lz = 7'd0;
        found = 1'b0;
        for (int i = 63; i >= 0; i--) begin
            if (!found && mag[i]) begin
                found = 1'b1;
                lz = 7'(63 - i);
            end
        end
        norm = mag << lz;
        mant = norm[63:11];
        // Round to nearest even on the dropped eleven bits.
        rnd = norm[10] && ((|norm[9:0]) || norm[11]);
        mant_r = {1'b0, mant} + 54'(rnd);
        // Value = norm * 2^(31 - lz); exponent field = 1023 + 31 - lz.
        e_base = 11'(EXP_BIAS + 31) - 11'(lz);
        if (mant_r[53]) begin
            expo = e_base + 11'd1;
        end else begin
            expo = e_base;
        end
        if (!found) begin
            o_double = {sgn, 63'd0};
        end else begin
            o_double = {sgn, expo, (mant_r[53] ? 52'd0 : mant_r[51:0])};
        end
    end
endmodule

// ----- rtl/nfdc_to_fix.sv -----
// Binary64 to fixed-point (long or short) conversion with truncation and saturation; NaN and out-of-range set o_flag.
// Depends on nfdc_pkg.
`timescale 1ns / 1ps
module nfdc_to_fix
    import nfdc_pkg::*;
(
    input  logic        i_short,
    input  logic [63:0] i_double,
    output logic [63:0] o_fixed,
    output logic        o_flag
);
    logic        sgn;
    logic [10:0] ex;
    logic [51:0] fr;
    logic        is_nan;
    logic        neg;
    logic [52:0] sig;
    logic [11:0] lim;
    logic [116:0] wide;
    logic [63:0] mag;
    logic [12:0] sh;

    always_comb begin
        sgn = i_double[63];
        ex = i_double[62:52];
        fr = i_double[51:0];
        is_nan = (&ex) && (|fr);
        neg = sgn && ((|ex) || (|fr));
        sig = {(|ex), fr};
        lim = i_short ? 12'(EXP_BIAS + 16) : 12'(EXP_BIAS + 32);
        // mag (as 32.32) = sig * 2^(e - 1075 + 32); shift sig left by e - 990
        // and keep bits 116..53, so the kept word is sig * 2^(e - 1043).
        wide = '0;
        mag = '0;
        sh = 13'd0;
        if ({1'b0, ex} >= 12'(EXP_BIAS - 33)) begin
            sh = 13'({2'b0, ex} - 13'(EXP_BIAS - 33));
            wide = {64'd0, sig} << sh;
            mag = wide[116:53];
        end
        o_flag = 1'b0;
        o_fixed = '0;
        if (is_nan) begin
            o_flag = 1'b1;
        end else if ({1'b0, ex} >= lim) begin
            o_flag = 1'b1;
            o_fixed = i_short ? 64'h0000_0000_FFFF_FFFF : '1;
        end else if (i_short) begin
            o_fixed = {32'd0, (neg ? ~mag[47:16] : mag[47:16])};
        end else begin
            o_fixed = neg ? ~mag : mag;
        end
    end
endmodule

// ----- rtl/ntp_fixed_double_convert.sv -----
// NTP fixed-point / IEEE-754 binary64 converter, top level.
// An accepted item goes to the input register, then its result to the result register.
// Throughput: one item per cycle unless the output stalls; an input register and a result
// register frame one stage of conversion logic, and an empty input register still accepts.
// Reset: synchronous active-low i_rst_n clears both valid flags only.
// Depends on nfdc_pkg, nfdc_if, nfdc_to_dbl and nfdc_to_fix.
`timescale 1ns / 1ps
module ntp_fixed_double_convert
    import nfdc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    nfdc_in_if.sink    i_in,
    nfdc_out_if.source o_out
);
    // Stage one holds the accepted item; stage two holds its result.
    logic        r_in_vld;
    t_op         r_op;
    logic [63:0] r_fw;
    logic [63:0] r_db;
    logic        r_out_vld;
    t_result     r_res;
    t_result     n_res;
    logic [63:0] dbl_c;
    logic [63:0] fix_c;
    logic        flag_c;
    logic        adv;

    // The pipe moves whenever the result slot is empty or being drained.
    assign adv = !r_out_vld || o_out.ready;
    assign i_in.ready = adv || !r_in_vld;

    nfdc_to_dbl u_to_dbl (
        .i_short  (r_op == OP_SHORT_TO_DBL),
        .i_word   (r_fw),
        .o_double (dbl_c)
    );

    nfdc_to_fix u_to_fix (
        .i_short  (r_op == OP_DBL_TO_SHORT),
        .i_double (r_db),
        .o_fixed  (fix_c),
        .o_flag   (flag_c)
    );

    // Only the converter selected by the operation contributes to the result.
    always_comb begin
        n_res = '0;
        case (r_op)
            OP_LONG_TO_DBL, OP_SHORT_TO_DBL: begin
                n_res.double_result = dbl_c;
            end
            OP_DBL_TO_LONG, OP_DBL_TO_SHORT: begin
                n_res.fixed_result = fix_c;
                n_res.out_of_range = flag_c;
            end
            default: begin
                n_res = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_in.ready) begin
                r_in_vld <= i_in.valid;
            end
            if (adv) begin
                r_out_vld <= r_in_vld;
            end
        end
        if (i_in.valid && i_in.ready) begin
            r_op <= t_op'(i_in.operation);
            r_fw <= i_in.fixed_word;
            r_db <= i_in.double_bits;
        end
        if (adv && r_in_vld) begin
            r_res <= n_res;
        end
    end

    assign o_out.valid         = r_out_vld;
    assign o_out.double_result = r_res.double_result;
    assign o_out.fixed_result  = r_res.fixed_result;
    assign o_out.out_of_range  = r_res.out_of_range;

    // A stalled result must not change underneath the consumer.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !o_out.ready) |=> (r_out_vld && $stable(r_res)))
        else $error("result changed while stalled");

    // The flag is only raised by the double-to-fixed operations.
    a_flag_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_res.out_of_range) |-> (r_res.double_result == 64'd0))
        else $error("flag raised on a fixed-to-double item");

    // An item waiting in stage one is never dropped by a stall.
    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && !adv) |=> r_in_vld)
        else $error("staged item lost");
endmodule
